[hdl/hdif_pkg.sv]
`default_nettype none
package hdif_pkg;

	// width of the descriptor byte offset counter
	localparam int unsigned OFFSET_BITS = 16;
	localparam int unsigned ITEM_OFFSET_W = 16;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNCATED = 2'd1;
	localparam logic [1:0] ST_BAD_TAG   = 2'd2;

	localparam logic [1:0] TYPE_MAIN     = 2'd0;
	localparam logic [1:0] TYPE_RESERVED = 2'd3;

	localparam logic [7:0] LONG_PREFIX   = 8'hFE;
	localparam logic [1:0] SIZE_CODE_4   = 2'd3;
	localparam logic [3:0] MIN_MAIN_TAG  = 4'h8;

	typedef struct packed {
		logic                     valid;
		logic                     is_long_item;
		logic [1:0]               item_class;
		logic [7:0]               item_tag;
		logic [7:0]               data_length;
		logic [31:0]              data_value;
		logic [ITEM_OFFSET_W-1:0] item_offset;
		logic [1:0]               status;
	} hdif_result_t;

	// cap the internal offset at the 16-bit reporting range
	function automatic logic [ITEM_OFFSET_W-1:0] cap_offset(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[ITEM_OFFSET_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/hdif_framer.sv]
`default_nettype none
module hdif_framer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 end_of_descriptor,
	output hdif_pkg::hdif_result_t    res
);
	import hdif_pkg::*;

	localparam logic [2:0] PH_PREFIX     = 3'd0;
	localparam logic [2:0] PH_SHORT_DATA = 3'd1;
	localparam logic [2:0] PH_LONG_SIZE  = 3'd2;
	localparam logic [2:0] PH_LONG_TAG   = 3'd3;
	localparam logic [2:0] PH_LONG_DATA  = 3'd4;
	localparam logic [2:0] PH_DROP       = 3'd5;

	logic [2:0]             phase_q, phase_d, phase_w;
	logic [7:0]             bytes_left_q, bytes_left_d, bytes_left_w;
	logic [31:0]            accum_q, accum_d;
	logic [1:0]             type_q, type_d;
	logic [7:0]             tag_q, tag_d;
	logic [7:0]             len_q, len_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_w;
	logic [OFFSET_BITS-1:0] start_q, start_d;

	logic       emit, emit_long;
	logic [1:0] emit_status;
	logic [1:0] size_code, pfx_type;
	logic [3:0] pfx_tag;
	logic [7:0] n_bytes;
	logic [1:0] idx;

	always_comb begin
		size_code   = in_byte[1:0];
		pfx_type    = in_byte[3:2];
		pfx_tag     = in_byte[7:4];
		n_bytes     = (size_code == SIZE_CODE_4) ? 8'd4 : 8'(size_code);
		idx         = 2'(len_q - bytes_left_q);
		phase_w     = phase_q;
		bytes_left_w = bytes_left_q;
		accum_d     = accum_q;
		type_d      = type_q;
		tag_d       = tag_q;
		len_d       = len_q;
		start_d     = start_q;
		emit        = 1'b0;
		emit_long   = 1'b0;
		emit_status = ST_OK;

		unique case (phase_q)
			PH_PREFIX: begin
				start_d = pos_q;
				accum_d = '0;
				if (in_byte == LONG_PREFIX) begin
					type_d       = TYPE_RESERVED;
					tag_d        = '0;
					len_d        = '0;
					bytes_left_w = '0;
					phase_w      = PH_LONG_SIZE;
				end else begin
					type_d       = pfx_type;
					tag_d        = 8'(pfx_tag);
					len_d        = n_bytes;
					bytes_left_w = n_bytes;
					if (pfx_type == TYPE_MAIN && pfx_tag < MIN_MAIN_TAG) begin
						emit        = 1'b1;
						emit_status = ST_BAD_TAG;
						phase_w     = PH_DROP;
					end else if (n_bytes == 8'd0) begin
						emit = 1'b1;
					end else begin
						phase_w = PH_SHORT_DATA;
					end
				end
			end
			PH_SHORT_DATA: begin
				accum_d      = accum_q | (32'(in_byte) << {idx, 3'b000});
				bytes_left_w = bytes_left_q - 8'd1;
				if (bytes_left_w == 8'd0) begin
					emit    = 1'b1;
					phase_w = PH_PREFIX;
				end
			end
			PH_LONG_SIZE: begin
				len_d   = in_byte;
				phase_w = PH_LONG_TAG;
			end
			PH_LONG_TAG: begin
				tag_d        = in_byte;
				bytes_left_w = len_q;
				if (len_q == 8'd0) begin
					emit      = 1'b1;
					emit_long = 1'b1;
					phase_w   = PH_PREFIX;
				end else begin
					phase_w = PH_LONG_DATA;
				end
			end
			PH_LONG_DATA: begin
				bytes_left_w = bytes_left_q - 8'd1;
				if (bytes_left_w == 8'd0) begin
					emit      = 1'b1;
					emit_long = 1'b1;
					phase_w   = PH_PREFIX;
				end
			end
			PH_DROP: begin
			end
			default: begin
				phase_w = PH_PREFIX;
			end
		endcase

		// saturate the offset counter
		pos_w = (pos_q != '1) ? pos_q + OFFSET_BITS'(1) : pos_q;

		phase_d      = phase_w;
		bytes_left_d = bytes_left_w;
		pos_d        = pos_w;
		if (end_of_descriptor) begin
			// an unfinished item is reported as truncated
			if (!emit && phase_w != PH_PREFIX && phase_w != PH_DROP) begin
				emit        = 1'b1;
				emit_status = ST_TRUNCATED;
				emit_long   = (phase_w == PH_LONG_SIZE) || (phase_w == PH_LONG_TAG) ||
					(phase_w == PH_LONG_DATA);
			end
			phase_d      = PH_PREFIX;
			bytes_left_d = '0;
			pos_d        = '0;
		end

		res.valid        = step & emit;
		res.is_long_item = emit_long;
		res.item_class   = type_d;
		res.item_tag     = tag_d;
		res.data_length  = len_d;
		res.data_value   = emit_long ? 32'd0 : accum_d;
		res.item_offset  = cap_offset(start_d);
		res.status       = emit_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREFIX;
			bytes_left_q <= '0;
			accum_q      <= '0;
			type_q       <= '0;
			tag_q        <= '0;
			len_q        <= '0;
			pos_q        <= '0;
			start_q      <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			accum_q      <= accum_d;
			type_q       <= type_d;
			tag_q        <= tag_d;
			len_q        <= len_d;
			pos_q        <= pos_d;
			start_q      <= start_d;
		end
	end

	a_eod_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_descriptor |=> phase_q == PH_PREFIX && pos_q == '0)
		else $error("framer did not restart after end of descriptor");

	a_bad_tag_on_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_BAD_TAG |-> phase_q == PH_PREFIX && !res.is_long_item)
		else $error("bad main tag reported outside a prefix beat");

endmodule
`default_nettype wire

[hdl/hdif_out_stage.sv]
`default_nettype none
module hdif_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hdif_pkg::hdif_result_t res,
	output logic                   can_take,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,
	output logic [4:0]             m_tuser
);
	import hdif_pkg::*;

	hdif_result_t held_q;

	assign can_take = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (can_take) begin
			m_tvalid <= res.valid;
		end
	end

	// payload holds while the beat waits
	always_ff @(posedge clk) begin
		if (can_take && res.valid) begin
			held_q <= res;
		end
	end

	assign m_tdata = {held_q.item_offset, held_q.data_value, held_q.data_length,
		held_q.item_tag};
	assign m_tuser = {held_q.status, held_q.item_class, held_q.is_long_item};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && res.valid |-> !can_take)
		else $error("waiting result beat overwritten");

endmodule
`default_nettype wire

[hdl/hid_descriptor_item_framer_top.sv]
// Channel | dir | tdata (low bit up)                                     | tuser / tlast
// s_*     | in  | in_byte[7:0]                                           | tlast = end_of_descriptor
// m_*     | out | item_tag[7:0], data_length[15:8], data_value[47:16],   | tuser = is_long_item[0],
//         |     | item_offset[63:48]                                     | item_class[2:1], status[4:3]
//
// One descriptor byte per clock while the output is not stalled: a beat is
// registered at the input, framed by the byte state machine and its result
// (if any) lands in the output register. The framing state and offset
// counter are the only feedback loop.
// Reset clears the input and output valid flags and all framing state.
// A stalled output holds its beat; the input register then stops advancing
// and s_tready drops once it is full.
`default_nettype none
module hid_descriptor_item_framer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // in_byte
	input  wire logic        s_tlast,   // end_of_descriptor
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // item_tag, data_length, data_value, item_offset
	output logic [4:0]       m_tuser    // is_long_item, item_class, status
);
	import hdif_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         can_take;
	logic         advance;
	hdif_result_t res;

	// advance the held byte only when the output register can take a result
	assign advance  = valid_s1 && can_take;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hdif_framer u_framer (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.in_byte           (byte_s1),
		.end_of_descriptor (last_s1),
		.res               (res)
	);

	hdif_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.can_take (can_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

endmodule
`default_nettype wire
